>>> src/wssb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wssb_pkg
// Shared types, codes and constants of the wrapping sequence slot buffer.
// ----------------------------------------------------------------------------
package wssb_pkg;

   localparam int NUM_SLOTS_DEF  = 256;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int MAX_DATA_W     = 64;

   localparam int CMD_W       = 3;
   localparam int SEQ_W       = 16;
   localparam int PAYLOAD_W   = 32;
   localparam int SEL_W       = 8;
   localparam int ACK_MAP_W   = 32;
   localparam int ACK_CNT_W   = 6;
   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 88;

   localparam logic [SEQ_W-1:0] HALF_RANGE = 16'h8000;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR       = 3'd0,
      CMD_INSERT      = 3'd1,
      CMD_ADVANCE     = 3'd2,
      CMD_REMOVE      = 3'd3,
      CMD_FIND        = 3'd4,
      CMD_ACK         = 3'd5,
      CMD_READ_SLOT   = 3'd6,
      CMD_TEST_INSERT = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_APPLY,
      ST_READ,
      ST_ACK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic decide;
      logic apply;
      logic rd;
      logic ack_step;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic    out_free;
      logic    ack_done;
   } ctrl_sts_type;

   // a is newer than b under the half-range rule
   function automatic logic seq_newer(input logic [SEQ_W-1:0] a,
                                      input logic [SEQ_W-1:0] b);
      logic [SEQ_W-1:0] d;
      d = a - b;
      return (d != '0) && ((d < HALF_RANGE) || ((d == HALF_RANGE) && (a > b)));
   endfunction

endpackage

>>> src/wssb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wssb_ctrl
// Command sequencer: steps each accepted beat through those of decide, update,
// slot read and ack scan it needs; hands the result to the output register.
// ----------------------------------------------------------------------------
module wssb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  wssb_pkg::cmd_type      req_cmd,
   input  wssb_pkg::ctrl_sts_type sts,
   output wssb_pkg::ctrl_cmd_type cmd
);

   wssb_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wssb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wssb_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               case (req_cmd)
                  wssb_pkg::CMD_CLEAR,
                  wssb_pkg::CMD_REMOVE:      state_in = wssb_pkg::ST_APPLY;
                  wssb_pkg::CMD_INSERT,
                  wssb_pkg::CMD_ADVANCE,
                  wssb_pkg::CMD_TEST_INSERT: state_in = wssb_pkg::ST_DECIDE;
                  wssb_pkg::CMD_FIND,
                  wssb_pkg::CMD_READ_SLOT:   state_in = wssb_pkg::ST_READ;
                  wssb_pkg::CMD_ACK:         state_in = wssb_pkg::ST_ACK;
                  default:                   state_in = wssb_pkg::ST_IDLE;
               endcase
            end
         end
         wssb_pkg::ST_DECIDE: state_in = wssb_pkg::ST_APPLY;
         wssb_pkg::ST_APPLY:  state_in = wssb_pkg::ST_FINISH;
         wssb_pkg::ST_READ:   state_in = wssb_pkg::ST_FINISH;
         wssb_pkg::ST_ACK: begin
            if (sts.ack_done) begin
               state_in = wssb_pkg::ST_FINISH;
            end
         end
         wssb_pkg::ST_FINISH: begin
            if (sts.out_free) begin
               state_in = wssb_pkg::ST_IDLE;
            end
         end
         default: state_in = wssb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         wssb_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         wssb_pkg::ST_DECIDE: cmd.decide   = 1'b1;
         wssb_pkg::ST_APPLY:  cmd.apply    = 1'b1;
         wssb_pkg::ST_READ:   cmd.rd       = 1'b1;
         wssb_pkg::ST_ACK:    cmd.ack_step = 1'b1;
         wssb_pkg::ST_FINISH: cmd.finish   = sts.out_free;
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

>>> src/wssb_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wssb_datapath
// Beat registers, window state, valid flags, slot memory, ack scan and the
// output register.
// ----------------------------------------------------------------------------
module wssb_datapath #(
   parameter int NUM_SLOTS  = wssb_pkg::NUM_SLOTS_DEF,
   parameter int DATA_WIDTH = wssb_pkg::DATA_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  wssb_pkg::ctrl_cmd_type            cmd,
   output wssb_pkg::ctrl_sts_type            sts,
   input  logic [wssb_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic [wssb_pkg::CMD_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [wssb_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   localparam int IDX_W = $clog2(NUM_SLOTS);
   localparam int SEQ_W = wssb_pkg::SEQ_W;
   localparam logic [SEQ_W-1:0] SLOTS_SEQ = SEQ_W'(NUM_SLOTS);
   localparam logic [SEQ_W:0]   SLOTS_CMP = (SEQ_W + 1)'(NUM_SLOTS);

   // beat registers
   wssb_pkg::cmd_type                cmd_ff;
   logic [SEQ_W-1:0]                 seq_ff;
   logic [DATA_WIDTH-1:0]            pay_ff;
   logic [wssb_pkg::SEL_W-1:0]       sel_ff;
   logic [wssb_pkg::MAX_DATA_W-1:0]  pay_wide;

   // window state
   logic [SEQ_W-1:0]     ne_ff, ne_in;
   logic [NUM_SLOTS-1:0] valid_ff, valid_in;
   logic                 inwin_ff, adv_ff, full_ff;
   logic [IDX_W-1:0]     gap_ff;
   logic [SEQ_W-1:0]     oldest, gap;
   logic [IDX_W-1:0]     seq_idx, off;
   int                   i;

   // slot memory
   logic [SEQ_W-1:0]      slot_seq_ff [NUM_SLOTS];
   logic [DATA_WIDTH-1:0] slot_pay_ff [NUM_SLOTS];
   logic [SEQ_W-1:0]      rd_seq_ff;
   logic [DATA_WIDTH-1:0] rd_pay_ff;
   logic                  rd_valid_ff;
   logic                  mem_we, mem_re;
   logic [IDX_W-1:0]      raddr;
   logic [SEQ_W-1:0]      sel_wide;

   // ack scan
   logic [wssb_pkg::ACK_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           pend_ff, pend_in;
   logic [SEQ_W-1:0]               exp_ff, exp_in, top;
   logic [wssb_pkg::ACK_MAP_W-1:0] map_ff;
   logic                           ack_issue;

   // result
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [wssb_pkg::RSP_TDATA_W-1:0] rsp_data_ff;
   logic                            res_acc, res_found, res_free, in_range;
   logic [wssb_pkg::MAX_DATA_W-1:0] rd_wide;
   logic [wssb_pkg::PAYLOAD_W-1:0]  res_data;
   logic [SEQ_W-1:0]                res_ack_seq;
   logic [wssb_pkg::ACK_MAP_W-1:0]  res_map;

   assign pay_wide = {{(wssb_pkg::MAX_DATA_W - wssb_pkg::PAYLOAD_W){1'b0}},
                      req_tdata[47:16]};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= wssb_pkg::cmd_type'(req_tuser);
         seq_ff <= req_tdata[15:0];
         pay_ff <= pay_wide[DATA_WIDTH-1:0];
         sel_ff <= req_tdata[55:48];
      end
   end

   assign seq_idx = seq_ff[IDX_W-1:0];
   assign oldest  = ne_ff - SLOTS_SEQ;
   assign gap     = seq_ff - ne_ff;

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         inwin_ff <= !wssb_pkg::seq_newer(oldest, seq_ff);
         adv_ff   <= wssb_pkg::seq_newer(seq_ff + 16'd1, ne_ff);
         full_ff  <= ({1'b0, gap} >= SLOTS_CMP);
         gap_ff   <= gap[IDX_W-1:0];
      end
   end

   // window update
   always_comb begin
      ne_in    = ne_ff;
      valid_in = valid_ff;
      mem_we   = 1'b0;
      off      = '0;
      if (cmd.apply) begin
         case (cmd_ff)
            wssb_pkg::CMD_CLEAR: begin
               ne_in    = '0;
               valid_in = '0;
            end
            wssb_pkg::CMD_INSERT,
            wssb_pkg::CMD_ADVANCE: begin
               if ((inwin_ff || cmd_ff == wssb_pkg::CMD_ADVANCE) && adv_ff) begin
                  ne_in = seq_ff + 16'd1;
                  for (i = 0; i < NUM_SLOTS; i++) begin
                     off = IDX_W'(i) - ne_ff[IDX_W-1:0];
                     if (full_ff || off <= gap_ff) begin
                        valid_in[i] = 1'b0;
                     end
                  end
               end
               if (cmd_ff == wssb_pkg::CMD_INSERT && inwin_ff) begin
                  valid_in[seq_idx] = 1'b1;
                  mem_we            = 1'b1;
               end
            end
            wssb_pkg::CMD_REMOVE: valid_in[seq_idx] = 1'b0;
            default: begin
               ne_in = ne_ff;
            end
         endcase
      end
   end

   // ack scan control
   assign top       = ne_ff - 16'd1;
   assign ack_issue = cmd.ack_step &&
                      (cnt_ff < wssb_pkg::ACK_CNT_W'(wssb_pkg::ACK_MAP_W));
   assign exp_in    = top - SEQ_W'(cnt_ff);

   always_comb begin
      cnt_in  = cnt_ff;
      pend_in = ack_issue;
      if (cmd.load) begin
         cnt_in  = '0;
         pend_in = 1'b0;
      end else if (ack_issue) begin
         cnt_in = cnt_ff + wssb_pkg::ACK_CNT_W'(1);
      end
   end

   assign sel_wide = {{(SEQ_W - wssb_pkg::SEL_W){1'b0}}, sel_ff};
   assign mem_re   = cmd.rd || ack_issue;

   always_comb begin
      if (ack_issue) begin
         raddr = exp_in[IDX_W-1:0];
      end else if (cmd_ff == wssb_pkg::CMD_READ_SLOT) begin
         raddr = sel_wide[IDX_W-1:0];
      end else begin
         raddr = seq_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_seq_ff[seq_idx] <= seq_ff;
         slot_pay_ff[seq_idx] <= pay_ff;
      end
      if (mem_re) begin
         rd_seq_ff   <= slot_seq_ff[raddr];
         rd_pay_ff   <= slot_pay_ff[raddr];
         rd_valid_ff <= valid_ff[raddr];
      end
      if (ack_issue) begin
         exp_ff <= exp_in;
      end
      if (cmd.load) begin
         map_ff <= '0;
      end else if (pend_ff) begin
         map_ff <= {rd_valid_ff && (rd_seq_ff == exp_ff),
                    map_ff[wssb_pkg::ACK_MAP_W-1:1]};
      end
   end

   // result forming
   always_comb begin
      rd_wide                 = '0;
      rd_wide[DATA_WIDTH-1:0] = rd_pay_ff;
      in_range  = ({1'b0, sel_wide} < SLOTS_CMP);
      res_acc   = (cmd_ff == wssb_pkg::CMD_INSERT || cmd_ff == wssb_pkg::CMD_TEST_INSERT)
                  && inwin_ff;
      res_found = 1'b0;
      res_free  = 1'b0;
      case (cmd_ff)
         wssb_pkg::CMD_FIND: begin
            res_found = rd_valid_ff && (rd_seq_ff == seq_ff);
            res_free  = !rd_valid_ff;
         end
         wssb_pkg::CMD_READ_SLOT: res_found = in_range && rd_valid_ff;
         default:                 res_found = 1'b0;
      endcase
      res_data    = res_found ? rd_wide[wssb_pkg::PAYLOAD_W-1:0] : '0;
      res_ack_seq = (cmd_ff == wssb_pkg::CMD_ACK) ? top : '0;
      res_map     = (cmd_ff == wssb_pkg::CMD_ACK) ? map_ff : '0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_data_ff <= {5'b0, res_map, res_ack_seq, res_data, res_free, res_found, res_acc};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ne_ff        <= '0;
         valid_ff     <= '0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ne_ff        <= ne_in;
         valid_ff     <= valid_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign sts.out_free = !rsp_valid_ff || rsp_tready;
   assign sts.ack_done = (cnt_ff == wssb_pkg::ACK_CNT_W'(wssb_pkg::ACK_MAP_W)) && !pend_ff;

endmodule

>>> src/wrapping_sequence_slot_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrapping_sequence_slot_buffer
// Slot table indexed by 16-bit wrapping sequence numbers with window
// tracking, lookup and a 32-bit ack presence map.
//
//   channel  dir  beat contents
//   req_     in   tuser: command; tdata: seq_number, payload, slot_index
//   rsp_     out  tdata: accepted, found, slot_free, read_data,
//                        ack_sequence, ack_map
//
// one beat in service at a time, one result beat per request beat
// insert, advance, test insert: decide, apply; clear, remove: apply only
// find, read slot: slot read; ack map: 32 reads of the single slot memory port
// a new request is taken while the previous result waits in rsp_
// synchronous active-high reset empties the window; no clearing pass
// ----------------------------------------------------------------------------
module wrapping_sequence_slot_buffer #(
   parameter int NUM_SLOTS  = wssb_pkg::NUM_SLOTS_DEF,
   parameter int DATA_WIDTH = wssb_pkg::DATA_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // seq_number[15:0], payload[47:16], slot_index[55:48]
   input  logic [wssb_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // command[2:0]
   input  logic [wssb_pkg::CMD_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // accepted[0], found[1], slot_free[2], read_data[34:3],
   // ack_sequence[50:35], ack_map[82:51], zero fill [87:83]
   output logic [wssb_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   wssb_pkg::ctrl_cmd_type ctrl_cmd;
   wssb_pkg::ctrl_sts_type ctrl_sts;

   wssb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (wssb_pkg::cmd_type'(req_tuser)),
      .sts        (ctrl_sts),
      .cmd        (ctrl_cmd)
   );

   wssb_datapath #(
      .NUM_SLOTS  (NUM_SLOTS),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (ctrl_cmd),
      .sts        (ctrl_sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
